@@ src/bcg_pkg.sv @@
package bcg_pkg;

    // Event action codes.
    localparam logic [2:0] ACT_PRESS   = 3'd0;
    localparam logic [2:0] ACT_RELEASE = 3'd1;
    localparam logic [2:0] ACT_CLICK   = 3'd2;
    localparam logic [2:0] ACT_DOUBLE  = 3'd3;
    localparam logic [2:0] ACT_LONG    = 3'd4;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_STABLE = 3'd1;
    localparam logic [2:0] REG_TPS    = 3'd2;
    localparam logic [2:0] REG_MAXSEC = 3'd3;
    localparam logic [2:0] REG_DCT    = 3'd4;

    // Micro-operations driven into the datapath.
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_ACCEPT    = 4'd1;
    localparam logic [3:0] OP_DEBOUNCE  = 4'd2;
    localparam logic [3:0] OP_DIV_START = 4'd3;
    localparam logic [3:0] OP_LONG_PRE  = 4'd4;
    localparam logic [3:0] OP_EMIT_LONG = 4'd5;
    localparam logic [3:0] OP_TIMEOUT   = 4'd6;
    localparam logic [3:0] OP_FINISH    = 4'd7;
    localparam logic [3:0] OP_PRESS     = 4'd8;
    localparam logic [3:0] OP_RELEASE   = 4'd9;
    localparam logic [3:0] OP_REL_POST  = 4'd10;

    // Branch kinds.
    localparam logic [1:0] BR_NEXT = 2'd0;
    localparam logic [1:0] BR_IF   = 2'd1;
    localparam logic [1:0] BR_IFN  = 2'd2;

    // Branch conditions.
    localparam logic [2:0] C_ALWAYS   = 3'd0;
    localparam logic [2:0] C_IN_VALID = 3'd1;
    localparam logic [2:0] C_ENABLE   = 3'd2;
    localparam logic [2:0] C_CHANGE   = 3'd3;
    localparam logic [2:0] C_STABLE   = 3'd4;
    localparam logic [2:0] C_DIV_BUSY = 3'd5;
    localparam logic [2:0] C_LONG_NEW = 3'd6;
    localparam logic [2:0] C_SAMPLE   = 3'd7;

    // Program addresses that are branch targets.
    localparam logic [3:0] PC_IDLE    = 4'd0;
    localparam logic [3:0] PC_DIV_W   = 4'd6;
    localparam logic [3:0] PC_TIMEOUT = 4'd10;
    localparam logic [3:0] PC_CHANGE  = 4'd12;
    localparam logic [3:0] PC_RELEASE = 4'd14;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] br;
        logic [2:0] cond;
        logic [3:0] target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic enable;
        logic change;
        logic stable;
        logic div_busy;
        logic long_new;
        logic sample;
    } t_cond;

    typedef struct packed {
        logic [2:0]  action;
        logic        held;
        logic [7:0]  secs;
        logic [31:0] tick;
    } t_event;

    typedef struct packed {
        logic blocked;
        logic stg_valid;
    } t_evq_stat;

    // Control program, one word per step.
    function automatic t_uword ucode(input logic [3:0] pc);
        t_uword w;
        case (pc)
            4'd0:  w = '{OP_ACCEPT,    BR_IFN,  C_IN_VALID, PC_IDLE};
            4'd1:  w = '{OP_NOP,       BR_IFN,  C_ENABLE,   PC_IDLE};
            4'd2:  w = '{OP_DEBOUNCE,  BR_NEXT, C_ALWAYS,   PC_IDLE};
            4'd3:  w = '{OP_NOP,       BR_IF,   C_CHANGE,   PC_CHANGE};
            4'd4:  w = '{OP_NOP,       BR_IFN,  C_STABLE,   PC_TIMEOUT};
            4'd5:  w = '{OP_DIV_START, BR_NEXT, C_ALWAYS,   PC_IDLE};
            4'd6:  w = '{OP_NOP,       BR_IF,   C_DIV_BUSY, PC_DIV_W};
            4'd7:  w = '{OP_NOP,       BR_IFN,  C_LONG_NEW, PC_TIMEOUT};
            4'd8:  w = '{OP_LONG_PRE,  BR_NEXT, C_ALWAYS,   PC_IDLE};
            4'd9:  w = '{OP_EMIT_LONG, BR_NEXT, C_ALWAYS,   PC_IDLE};
            4'd10: w = '{OP_TIMEOUT,   BR_NEXT, C_ALWAYS,   PC_IDLE};
            4'd11: w = '{OP_FINISH,    BR_IF,   C_ALWAYS,   PC_IDLE};
            4'd12: w = '{OP_NOP,       BR_IFN,  C_SAMPLE,   PC_RELEASE};
            4'd13: w = '{OP_PRESS,     BR_IF,   C_ALWAYS,   PC_TIMEOUT};
            4'd14: w = '{OP_RELEASE,   BR_NEXT, C_ALWAYS,   PC_IDLE};
            4'd15: w = '{OP_REL_POST,  BR_IF,   C_ALWAYS,   PC_TIMEOUT};
            default: w = '{OP_NOP,     BR_IF,   C_ALWAYS,   PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ src/button_click_gesture_classifier.sv @@
// Button gesture classifier: debounces polled button levels and reports press,
// release, click, double click and long-press events.
// Input channel s_axis: one request per poll, carrying the raw level and the
// current 32-bit tick. Output channel m_axis: up to two events per poll, with
// tlast set on the final event of the poll; a poll that causes no event sends
// nothing. The user must write configuration through the APB port only while
// the block idles; the block itself does not enforce this. While the button
// is held, each poll runs the serial divider, whose 32 one-bit iterations
// turn held ticks into seconds. The block takes one poll at a time and
// accepts the next when its control program returns to step 0.
// A finished event sits in the output register, so the next poll can be taken
// while it waits. If the receiver stalls with a second event pending, the
// program holds at that step until the output register drains.
// Synchronous reset puts the button in the released state, clears pending
// clicks and loads the register defaults (enable 1, 2 samples, 100 ticks per
// second, 15 seconds maximum, 50 double-click ticks).
module button_click_gesture_classifier import bcg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: sample_pressed[0], now_tick[32:1], zero pad [39:33].
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: action[2:0], held[3], hold_secs[11:4],
    // event_tick[43:12], zero pad [47:44].
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic        r_enable;
    logic [3:0]  r_ss;
    logic [15:0] r_tps;
    logic [7:0]  r_max;
    logic [15:0] r_dct;

    // Gesture state.
    logic        r_stable;
    logic        r_prev;
    logic [3:0]  r_run;
    logic        r_wait;
    logic [7:0]  r_rep;
    logic [31:0] r_press_t;
    logic [31:0] r_rel_t;

    // Current poll.
    logic        r_s;
    logic [31:0] r_now;
    logic [1:0]  r_nev;

    t_uword      uw;
    t_cond       cond;
    t_evq_stat   stat;
    t_event      ev;
    t_event      out_ev;
    logic        emit;
    logic        emit_q;
    logic        flush;
    logic        go;
    logic        accept;
    logic        cfg_wr;
    logic [3:0]  need;
    logic [15:0] tps;
    logic [15:0] dct;
    logic        change;
    logic        div_start;
    logic        div_busy;
    logic [31:0] quot;
    logic [7:0]  q_sat;
    logic        long_new;
    logic        tmo;
    logic [31:0] el_rel;

    bcg_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_cond  (cond),
        .o_uw    (uw)
    );

    bcg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_now - r_press_t),
        .i_den   (tps),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    bcg_evq u_evq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_emit   (emit_q),
        .i_flush  (flush),
        .i_ev     (ev),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_ev     (out_ev),
        .o_last   (m_axis_tlast),
        .o_stat   (stat)
    );

    assign m_axis_tdata  = {4'd0, out_ev.tick, out_ev.secs, out_ev.held, out_ev.action};
    assign s_axis_tready = (uw.op == OP_ACCEPT);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite;

    // Zero settings behave as one.
    assign need = (r_ss == 4'd0) ? 4'd1 : r_ss;
    assign tps  = (r_tps == 16'd0) ? 16'd1 : r_tps;
    assign dct  = (r_dct == 16'd0) ? 16'd1 : r_dct;

    // Datapath conditions.
    assign change   = (r_run >= need) && (r_s != r_stable);
    assign q_sat    = (quot > {24'd0, r_max}) ? r_max : quot[7:0];
    assign long_new = (q_sat != 8'd0) && (q_sat > r_rep);
    assign el_rel   = r_now - r_rel_t;
    assign tmo      = r_wait && (el_rel >= {16'd0, dct}) && (r_nev != 2'd2);
    assign div_start = (uw.op == OP_DIV_START);

    always_comb begin
        cond.in_valid = s_axis_tvalid;
        cond.enable   = r_enable;
        cond.change   = change;
        cond.stable   = r_stable;
        cond.div_busy = div_busy;
        cond.long_new = long_new;
        cond.sample   = r_s;
    end

    // Event selection for the current step.
    always_comb begin
        emit      = 1'b0;
        ev.action = ACT_CLICK;
        ev.held   = 1'b0;
        ev.secs   = 8'd0;
        ev.tick   = r_now;
        case (uw.op)
            OP_LONG_PRE: begin
                emit = r_wait;
            end
            OP_EMIT_LONG: begin
                emit      = 1'b1;
                ev.action = ACT_LONG;
                ev.held   = 1'b1;
                ev.secs   = r_rep;
            end
            OP_TIMEOUT: begin
                emit = tmo;
            end
            OP_PRESS: begin
                emit      = 1'b1;
                ev.action = ACT_PRESS;
                ev.held   = 1'b1;
            end
            OP_RELEASE: begin
                emit      = 1'b1;
                ev.action = ACT_RELEASE;
                ev.secs   = r_rep;
            end
            OP_REL_POST: begin
                emit      = (r_rep == 8'd0) && r_wait;
                ev.action = ACT_DOUBLE;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Emit and finish steps wait while an event is staged and the output stalls.
    assign flush  = (uw.op == OP_FINISH) && go;
    assign go     = !((emit || (uw.op == OP_FINISH)) && stat.stg_valid && stat.blocked);
    assign emit_q = emit && go;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_ss     <= 4'd2;
            r_tps    <= 16'd100;
            r_max    <= 8'd15;
            r_dct    <= 16'd50;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_ENABLE: r_enable <= pwdata[0];
                REG_STABLE: r_ss     <= pwdata[3:0];
                REG_TPS:    r_tps    <= pwdata[15:0];
                REG_MAXSEC: r_max    <= pwdata[7:0];
                REG_DCT:    r_dct    <= pwdata[15:0];
                default:    r_enable <= r_enable;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[4:2])
            REG_ENABLE: prdata = {31'd0, r_enable};
            REG_STABLE: prdata = {28'd0, r_ss};
            REG_TPS:    prdata = {16'd0, r_tps};
            REG_MAXSEC: prdata = {24'd0, r_max};
            REG_DCT:    prdata = {16'd0, r_dct};
            default:    prdata = 32'd0;
        endcase
    end

    // Poll capture.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s   <= s_axis_tdata[0];
            r_now <= s_axis_tdata[32:1];
        end
    end

    // Gesture state updates, one micro-operation per step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable  <= 1'b0;
            r_prev    <= 1'b0;
            r_run     <= 4'd0;
            r_wait    <= 1'b0;
            r_rep     <= 8'd0;
            r_press_t <= 32'd0;
            r_rel_t   <= 32'd0;
            r_nev     <= 2'd0;
        end else begin
            if (accept) begin
                r_nev <= 2'd0;
            end else if (emit_q) begin
                r_nev <= r_nev + 2'd1;
            end
            if (go) begin
                case (uw.op)
                    OP_DEBOUNCE: begin
                        if (r_s == r_prev) begin
                            if (r_run < need) begin
                                r_run <= r_run + 4'd1;
                            end
                        end else begin
                            r_prev <= r_s;
                            r_run  <= 4'd1;
                        end
                    end
                    OP_LONG_PRE: begin
                        r_rep  <= q_sat;
                        r_wait <= 1'b0;
                    end
                    OP_TIMEOUT: begin
                        if (tmo) begin
                            r_wait <= 1'b0;
                        end
                    end
                    OP_PRESS: begin
                        r_stable  <= 1'b1;
                        r_press_t <= r_now;
                        r_rep     <= 8'd0;
                    end
                    OP_RELEASE: begin
                        r_stable <= 1'b0;
                    end
                    OP_REL_POST: begin
                        if (r_rep == 8'd0) begin
                            if (r_wait) begin
                                r_wait <= 1'b0;
                            end else begin
                                r_wait  <= 1'b1;
                                r_rel_t <= r_now;
                            end
                        end else begin
                            r_wait <= 1'b0;
                        end
                        r_press_t <= 32'd0;
                        r_rep     <= 8'd0;
                    end
                    default: begin
                        r_run <= r_run;
                    end
                endcase
            end
        end
    end

    // The divider is idle whenever a new poll can be taken.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !div_busy)
        else $error("divider busy while waiting for a poll");

    // Every event of the previous poll has left the staging slot.
    a_stg_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !stat.stg_valid)
        else $error("staged event left behind at poll start");

    // A poll never causes a third event.
    a_two_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_q |-> (r_nev != 2'd2))
        else $error("more than two events for one poll");

    // A stalled step neither advances nor hands on an event.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !go |=> ($stable(r_nev) && m_axis_tvalid))
        else $error("sequencer moved on during an output stall");

endmodule

@@ src/bcg_div.sv @@
module bcg_div import bcg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quot
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [31:0] r_quo;
    logic [15:0] r_den;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        fits;

    // One restoring division step per cycle, quotient bits shift in at the bottom.
    always_comb begin
        trial = {r_rem, r_quo[31]};
        diff  = trial - {1'b0, r_den};
        fits  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= 16'd0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? diff[15:0] : trial[15:0];
            r_quo <= {r_quo[30:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;

endmodule

@@ src/bcg_seq.sv @@
module bcg_seq import bcg_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_go,
    input  t_cond  i_cond,
    output t_uword o_uw
);

    logic [3:0] r_pc;
    logic [3:0] n_pc;
    t_uword     uw;
    logic       hit;

    assign uw = ucode(r_pc);

    // Condition select and next step.
    always_comb begin
        case (uw.cond)
            C_ALWAYS:   hit = 1'b1;
            C_IN_VALID: hit = i_cond.in_valid;
            C_ENABLE:   hit = i_cond.enable;
            C_CHANGE:   hit = i_cond.change;
            C_STABLE:   hit = i_cond.stable;
            C_DIV_BUSY: hit = i_cond.div_busy;
            C_LONG_NEW: hit = i_cond.long_new;
            C_SAMPLE:   hit = i_cond.sample;
            default:    hit = 1'b0;
        endcase
        n_pc = r_pc;
        if (i_go) begin
            case (uw.br)
                BR_IF:   n_pc = hit ? uw.target : r_pc + 4'd1;
                BR_IFN:  n_pc = hit ? r_pc + 4'd1 : uw.target;
                default: n_pc = r_pc + 4'd1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uw = uw;

endmodule

@@ src/bcg_evq.sv @@
module bcg_evq import bcg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_emit,
    input  logic      i_flush,
    input  t_event    i_ev,
    input  logic      i_tready,
    output logic      o_tvalid,
    output t_event    o_ev,
    output logic      o_last,
    output t_evq_stat o_stat
);

    logic   r_stg_valid;
    t_event r_stg;
    logic   r_out_valid;
    t_event r_out;
    logic   r_out_last;

    // The newest event waits in the staging slot until it is known whether another follows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_emit) begin
                r_stg_valid <= 1'b1;
                if (r_stg_valid) begin
                    r_out_valid <= 1'b1;
                end
            end else if (i_flush && r_stg_valid) begin
                r_stg_valid <= 1'b0;
                r_out_valid <= 1'b1;
            end
        end
    end

    // Payload moves with the control above.
    always_ff @(posedge i_clk) begin
        if (i_emit) begin
            r_stg <= i_ev;
            if (r_stg_valid) begin
                r_out      <= r_stg;
                r_out_last <= 1'b0;
            end
        end else if (i_flush && r_stg_valid) begin
            r_out      <= r_stg;
            r_out_last <= 1'b1;
        end
    end

    assign o_tvalid         = r_out_valid;
    assign o_ev             = r_out;
    assign o_last           = r_out_last;
    assign o_stat.blocked   = r_out_valid && !i_tready;
    assign o_stat.stg_valid = r_stg_valid;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import bcg_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 100;
    localparam int LONG_STALL   = 400;
    localparam int RANDOM_POLLS = 600;
    localparam int PHASE_POLLS  = 100;

    // Register indexes that decode to no register.
    localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]  action;
        logic        held;
        logic [7:0]  secs;
        logic [31:0] tick;
        logic        last;
    } gesture_ev_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the registers.
    logic        cfg_enable;
    logic [3:0]  cfg_stable;
    logic [15:0] cfg_tps;
    logic [7:0]  cfg_max_secs;
    logic [15:0] cfg_dct;

    // Predictor copy of the classifier state.
    logic        st_level;
    logic        st_prev;
    logic [3:0]  st_run;
    logic        st_click;
    logic [7:0]  st_secs;
    logic [31:0] st_press_tick;
    logic [31:0] st_release_tick;

    gesture_ev_t expected_events[$];
    int          poll_event_count;
    int          error_count;
    int          polls_sent;
    int          cycle_count;
    logic [31:0] cur_tick;
    bit          no_idle;
    int          rx_hold_req;

    button_click_gesture_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Zero register values behave as one.
    function automatic logic [3:0] eff_need();
        return (cfg_stable == 4'd0) ? 4'd1 : cfg_stable;
    endfunction

    function automatic logic [31:0] eff_tps();
        return (cfg_tps == 16'd0) ? 32'd1 : {16'd0, cfg_tps};
    endfunction

    function automatic logic [31:0] eff_dct();
        return (cfg_dct == 16'd0) ? 32'd1 : {16'd0, cfg_dct};
    endfunction

    function automatic void reset_model();
        cfg_enable      = 1'b1;
        cfg_stable      = 4'd2;
        cfg_tps         = 16'd100;
        cfg_max_secs    = 8'd15;
        cfg_dct         = 16'd50;
        st_level        = 1'b0;
        st_prev         = 1'b0;
        st_run          = 4'd0;
        st_click        = 1'b0;
        st_secs         = 8'd0;
        st_press_tick   = 32'd0;
        st_release_tick = 32'd0;
    endfunction

    function automatic void add_event(input logic [2:0] act, input logic held,
                                      input logic [7:0] secs, input logic [31:0] tick);
        expected_events.push_back('{act, held, secs, tick, 1'b0});
        poll_event_count++;
    endfunction

    // Works out the events that one accepted poll causes.
    function automatic void predict_poll(input logic level, input logic [31:0] now);
        logic [31:0] quot;
        logic [31:0] since_release;
        gesture_ev_t tail;
        poll_event_count = 0;
        if (cfg_enable) begin
            // Run-length debounce.
            if (level == st_prev) begin
                if (st_run < eff_need())
                    st_run = st_run + 4'd1;
            end else begin
                st_prev = level;
                st_run  = 4'd1;
            end

            if (st_run >= eff_need() && level != st_level) begin
                st_level = level;
                if (level) begin
                    st_press_tick = now;
                    st_secs       = 8'd0;
                    add_event(ACT_PRESS, 1'b1, 8'd0, now);
                end else begin
                    add_event(ACT_RELEASE, 1'b0, st_secs, now);
                    if (st_secs != 8'd0) begin
                        // A long release drops a waiting click silently.
                        st_click = 1'b0;
                    end else if (st_click) begin
                        st_click = 1'b0;
                        add_event(ACT_DOUBLE, 1'b0, 8'd0, now);
                    end else begin
                        st_click        = 1'b1;
                        st_release_tick = now;
                    end
                    st_press_tick = 32'd0;
                    st_secs       = 8'd0;
                end
            end else if (st_level) begin
                // Whole seconds held, saturated at the limit.
                quot = (now - st_press_tick) / eff_tps();
                if (quot > {24'd0, cfg_max_secs})
                    quot = {24'd0, cfg_max_secs};
                if (quot != 32'd0 && quot > {24'd0, st_secs}) begin
                    st_secs = quot[7:0];
                    if (st_click) begin
                        st_click = 1'b0;
                        add_event(ACT_CLICK, 1'b0, 8'd0, now);
                    end
                    add_event(ACT_LONG, 1'b1, quot[7:0], now);
                end
            end

            // Double-click window expiry.
            since_release = now - st_release_tick;
            if (st_click && poll_event_count < 2 && since_release >= eff_dct()) begin
                st_click = 1'b0;
                add_event(ACT_CLICK, 1'b0, 8'd0, now);
            end

            if (poll_event_count > 0) begin
                tail = expected_events.pop_back();
                tail.last = 1'b1;
                expected_events.push_back(tail);
            end
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Compare every accepted event request with the oldest prediction.
    always @(posedge i_clk) begin
        gesture_ev_t exp_ev;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_events.size() == 0) begin
                $error("event with none predicted: tdata %h, tlast %b",
                       m_axis_tdata, m_axis_tlast);
                error_count++;
            end else begin
                exp_ev = expected_events.pop_front();
                compare_field("action", {29'd0, exp_ev.action}, {29'd0, m_axis_tdata[2:0]});
                compare_field("held", {31'd0, exp_ev.held}, {31'd0, m_axis_tdata[3]});
                compare_field("hold_secs", {24'd0, exp_ev.secs}, {24'd0, m_axis_tdata[11:4]});
                compare_field("event_tick", exp_ev.tick, m_axis_tdata[43:12]);
                compare_field("last", {31'd0, exp_ev.last}, {31'd0, m_axis_tlast});
            end
        end
    end

    // Event receiver with random stalls and an optional long hold-off.
    initial begin : event_receiver
        int stall;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req > 0) begin
                stall = rx_hold_req;
                rx_hold_req = 0;
            end else if (no_idle) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 5);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // One APB write; the predictor takes the masked value.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLE: cfg_enable   = value[0];
            REG_STABLE: cfg_stable   = value[3:0];
            REG_TPS:    cfg_tps      = value[15:0];
            REG_MAXSEC: cfg_max_secs = value[7:0];
            REG_DCT:    cfg_dct      = value[15:0];
            default: ;
        endcase
    endtask

    // Sends one poll request; valid stays high when the next one follows at once.
    task automatic send_poll(input logic level, input logic [31:0] tick);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, tick, level};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_poll(level, tick);
        polls_sent++;
    endtask

    task automatic poll(input logic level, input int unsigned adv);
        cur_tick = cur_tick + adv;
        send_poll(level, cur_tick);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_events.size() != 0);
    endtask

    // Lets the block go idle before registers change.
    task automatic drain_and_settle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // A press held over extra polls, then a release over extra polls.
    task automatic press_release(input int hold_polls, input int unsigned hold_step,
                                 input int rel_polls, input int unsigned rel_step);
        repeat (eff_need() + hold_polls)
            poll(1'b1, $urandom_range(hold_step / 2, hold_step));
        repeat (eff_need() + rel_polls)
            poll(1'b0, $urandom_range(rel_step / 2, rel_step));
    endtask

    // One gesture with random content, shaped by the current registers.
    task automatic random_gesture();
        int          kind;
        int          n;
        int unsigned tps;
        int unsigned dct;
        int unsigned short_step;
        tps = eff_tps();
        dct = eff_dct();
        short_step = tps / (2 * eff_need() + 6);
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                // Noise: random levels, random steps and full-range tick jumps.
                n = $urandom_range(1, 8);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) begin
                        cur_tick = $urandom;
                        poll(1'($urandom_range(0, 1)), 0);
                    end else begin
                        poll(1'($urandom_range(0, 1)), $urandom_range(0, 2 * dct));
                    end
                end
            end
            1, 2, 3: begin
                // Single click that waits out the double-click window.
                press_release($urandom_range(0, 2), short_step,
                              $urandom_range(1, 4), dct / 2 + 1);
            end
            4, 5: begin
                // Two quick clicks.
                press_release($urandom_range(0, 2), short_step, 0, dct / (2 * eff_need() + 6));
                press_release($urandom_range(0, 2), short_step, $urandom_range(0, 3), dct / 4);
            end
            6, 7: begin
                // Long press rising second by second, maybe past the limit.
                n = $urandom_range(1, (cfg_max_secs > 8'd17) ? 20 : cfg_max_secs + 3);
                repeat (eff_need()) poll(1'b1, short_step);
                repeat (n) poll(1'b1, $urandom_range(tps / 2, tps + tps / 4));
                repeat (eff_need() + $urandom_range(0, 2)) poll(1'b0, short_step);
            end
            8: begin
                // Held across a huge tick jump, which saturates or wraps.
                repeat (eff_need()) poll(1'b1, short_step);
                poll(1'b1, $urandom);
                poll(1'b1, $urandom_range(0, tps));
                repeat (eff_need()) poll(1'b0, short_step);
            end
            default: begin
                // Contact bounce before a clean click.
                n = $urandom_range(2, 6);
                repeat (n) begin
                    poll(1'b1, short_step);
                    poll(1'b0, short_step);
                end
                press_release(0, short_step, $urandom_range(0, 3), dct / 2 + 1);
            end
        endcase
    endtask

    // Hand-picked polls at the reset settings: every event kind and tick wrap.
    task automatic test_directed_gestures();
        // Press, short release, click exactly at the timeout.
        send_poll(1'b1, 32'd0);
        send_poll(1'b1, 32'd1);
        send_poll(1'b0, 32'd10);
        send_poll(1'b0, 32'd12);
        send_poll(1'b0, 32'd62);
        // Double click.
        send_poll(1'b1, 32'd100);
        send_poll(1'b1, 32'd101);
        send_poll(1'b0, 32'd105);
        send_poll(1'b0, 32'd106);
        send_poll(1'b1, 32'd110);
        send_poll(1'b1, 32'd111);
        send_poll(1'b0, 32'd115);
        send_poll(1'b0, 32'd116);
        // A waiting click is flushed when a long press begins; seconds saturate.
        send_poll(1'b1, 32'd200);
        send_poll(1'b1, 32'd201);
        send_poll(1'b0, 32'd205);
        send_poll(1'b0, 32'd206);
        send_poll(1'b1, 32'd210);
        send_poll(1'b1, 32'd211);
        send_poll(1'b1, 32'd320);
        send_poll(1'b1, 32'd4211);
        send_poll(1'b0, 32'd5000);
        send_poll(1'b0, 32'd5001);
        // Hold time measured across the tick wrap.
        send_poll(1'b1, 32'hFFFF_FFF0);
        send_poll(1'b1, 32'hFFFF_FFFF);
        send_poll(1'b1, 32'h0000_0063);
        send_poll(1'b0, 32'h0000_0070);
        send_poll(1'b0, 32'h0000_0071);
        cur_tick = 32'h0000_0071;
        drain_and_settle();
    endtask

    // Register extremes, zero values, the disabled mode and spare addresses.
    task automatic test_register_corners();
        // Disabled: polls have no effect at all.
        reg_write(REG_ENABLE, 32'd0);
        repeat (8) begin
            cur_tick = $urandom;
            poll(1'($urandom_range(0, 1)), 0);
        end
        drain_and_settle();
        reg_write(REG_ENABLE, 32'hFFFF_FFFF);
        cur_tick = 32'd1000;

        // Zero counts behave as one.
        reg_write(REG_STABLE, 32'hFFFF_FFF0);
        reg_write(REG_TPS, 32'h1234_0000);
        reg_write(REG_DCT, 32'd0);
        poll(1'b1, 1);
        poll(1'b1, 0);
        poll(1'b1, 3);
        poll(1'b0, 1);
        poll(1'b0, 0);
        poll(1'b0, 2);
        poll(1'b1, 0);
        poll(1'b0, 0);
        poll(1'b1, 0);
        poll(1'b0, 0);
        drain_and_settle();

        // A zero limit never reports a long press.
        reg_write(REG_MAXSEC, 32'd0);
        reg_write(REG_STABLE, 32'd15);
        reg_write(REG_TPS, 32'd65535);
        press_release(4, 40000, 2, 10);
        drain_and_settle();

        // One-tick seconds with the full limit saturate at 255.
        reg_write(REG_MAXSEC, 32'd255);
        reg_write(REG_TPS, 32'd1);
        reg_write(REG_STABLE, 32'd1);
        poll(1'b1, 0);
        poll(1'b1, 100);
        poll(1'b1, 32'hFFFF_0000);
        poll(1'b0, 5);
        drain_and_settle();

        // Spare addresses change nothing.
        for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
            reg_write(3'(i), 32'hFFFF_FFFF);
        reg_write(REG_DCT, 32'd65535);
        reg_write(REG_TPS, 32'd65535);
        press_release(0, 1, 1, 1);
        press_release(0, 1, 1, 1);
        press_release(0, 1, 2, 40000);
        drain_and_settle();
    endtask

    // Random register settings, each phase followed by random gestures.
    task automatic test_random_settings();
        int          start_polls;
        int          phase_start;
        logic [3:0]  stable;
        logic [15:0] tps;
        logic [15:0] dct;
        logic [7:0]  maxs;
        start_polls = polls_sent;
        while (polls_sent - start_polls < RANDOM_POLLS) begin
            drain_and_settle();
            case ($urandom_range(0, 5))
                0: begin
                    stable = 4'd1;
                    tps    = 16'd1;
                    dct    = 16'd1;
                    maxs   = 8'd0;
                end
                1: begin
                    stable = 4'd15;
                    tps    = 16'hFFFF;
                    dct    = 16'hFFFF;
                    maxs   = 8'hFF;
                end
                default: begin
                    stable = 4'($urandom_range(0, 4));
                    tps    = 16'($urandom_range(1, 400));
                    dct    = 16'($urandom_range(1, 400));
                    maxs   = 8'($urandom_range(1, 20));
                end
            endcase
            // Bits above each field are noise that the block must drop.
            reg_write(REG_ENABLE, ($urandom & ~32'h1) | 32'h1);
            reg_write(REG_STABLE, ($urandom & ~32'hF) | {28'd0, stable});
            reg_write(REG_TPS, ($urandom & ~32'hFFFF) | {16'd0, tps});
            reg_write(REG_MAXSEC, ($urandom & ~32'hFF) | {24'd0, maxs});
            reg_write(REG_DCT, ($urandom & ~32'hFFFF) | {16'd0, dct});
            phase_start = polls_sent;
            while (polls_sent - phase_start < PHASE_POLLS) begin
                random_gesture();
                // Now and then the sender waits for every event to come back.
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
            end
        end
        drain_and_settle();
    endtask

    // The receiver holds off while every poll causes an event.
    task automatic test_output_stall();
        logic level;
        reg_write(REG_STABLE, 32'd1);
        reg_write(REG_TPS, 32'd65535);
        reg_write(REG_DCT, 32'd65535);
        reg_write(REG_MAXSEC, 32'd15);
        level = st_level;
        rx_hold_req = LONG_STALL;
        repeat (40) begin
            level = ~level;
            poll(level, 1);
        end
        drain_and_settle();
    endtask

    // Back-to-back requests on both sides.
    task automatic test_back_to_back();
        reg_write(REG_STABLE, 32'd2);
        reg_write(REG_TPS, 32'd20);
        reg_write(REG_DCT, 32'd30);
        reg_write(REG_MAXSEC, 32'd5);
        no_idle = 1'b1;
        repeat (12) random_gesture();
        no_idle = 1'b0;
        drain_and_settle();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        error_count = 0;
        polls_sent  = 0;
        cycle_count = 0;
        cur_tick    = 32'd0;
        no_idle     = 1'b0;
        rx_hold_req = 0;
        reset_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_gestures();
        test_register_corners();
        test_output_stall();
        test_back_to_back();
        test_random_settings();

        drain_and_settle();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ button_click_gesture_classifier.f @@
src/bcg_pkg.sv
src/bcg_div.sv
src/bcg_seq.sv
src/bcg_evq.sv
src/button_click_gesture_classifier.sv
verif/tb_top.sv
